[rtl/c2eu8_pkg.sv]
// Package: types, constants and code tables for the cp1252 to escaped UTF-8 converter.
`timescale 1ns / 1ps
`default_nettype none
package c2eu8_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;
   localparam int FIELD_COUNT_WIDTH   = 32;
   localparam int BYTE_WIDTH          = 8;
   localparam int MAX_BYTES           = 3;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;

   localparam logic [1:0] NEED_NONE  = 2'd0;
   localparam logic [1:0] NEED_ONE   = 2'd1;
   localparam logic [1:0] NEED_TWO   = 2'd2;
   localparam logic [1:0] NEED_THREE = 2'd3;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [1:0]                cnt;
      logic                      undef;
   } enc_type;

   // cp1252 0x80-0x9F to Unicode; zero marks an undefined byte
   function automatic logic [15:0] hi_map(input logic [4:0] idx);
      logic [15:0] u;
      case (idx)
         5'h00: u = 16'h20AC;
         5'h02: u = 16'h201A;
         5'h03: u = 16'h0192;
         5'h04: u = 16'h201E;
         5'h05: u = 16'h2026;
         5'h06: u = 16'h2020;
         5'h07: u = 16'h2021;
         5'h08: u = 16'h02C6;
         5'h09: u = 16'h2030;
         5'h0A: u = 16'h0160;
         5'h0B: u = 16'h2039;
         5'h0C: u = 16'h0152;
         5'h0E: u = 16'h017D;
         5'h11: u = 16'h2018;
         5'h12: u = 16'h2019;
         5'h13: u = 16'h201C;
         5'h14: u = 16'h201D;
         5'h15: u = 16'h2022;
         5'h16: u = 16'h2013;
         5'h17: u = 16'h2014;
         5'h18: u = 16'h02DC;
         5'h19: u = 16'h2122;
         5'h1A: u = 16'h0161;
         5'h1B: u = 16'h203A;
         5'h1C: u = 16'h0153;
         5'h1E: u = 16'h017E;
         5'h1F: u = 16'h0178;
         default: u = 16'h0000;
      endcase
      return u;
   endfunction

   function automatic enc_type encode(input logic [7:0] c);
      enc_type     e;
      logic [15:0] cp;
      logic [15:0] mapped;
      e      = '0;
      mapped = hi_map(c[4:0]);
      if (c[7:5] == 3'b100) begin
         if (mapped == 16'h0000) begin
            e.undef = 1'b1;
            cp      = {8'h00, c};
         end else begin
            cp = mapped;
         end
      end else begin
         cp = {8'h00, c};
      end
      if (c == 8'h00) begin
         e.cnt = 2'd0;
      end else if (cp == {8'h00, CH_BACKSLASH}) begin
         e.bytes[0] = CH_BACKSLASH;
         e.bytes[1] = CH_BACKSLASH;
         e.cnt      = 2'd2;
      end else if (cp == {8'h00, CH_TAB}) begin
         e.bytes[0] = CH_BACKSLASH;
         e.bytes[1] = CH_LOWER_T;
         e.cnt      = 2'd2;
      end else if (cp == {8'h00, CH_NEWLINE}) begin
         e.bytes[0] = CH_BACKSLASH;
         e.bytes[1] = CH_LOWER_N;
         e.cnt      = 2'd2;
      end else if (cp == {8'h00, CH_RETURN}) begin
         e.bytes[0] = CH_BACKSLASH;
         e.bytes[1] = CH_LOWER_R;
         e.cnt      = 2'd2;
      end else if (cp < 16'h0080) begin
         e.bytes[0] = cp[7:0];
         e.cnt      = 2'd1;
      end else if (cp < 16'h0800) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.cnt      = 2'd2;
      end else begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.cnt      = 2'd3;
      end
      return e;
   endfunction

endpackage
`default_nettype wire

[rtl/cp1252_to_escaped_utf8.sv]
// Top level: cp1252 to escaped UTF-8 converter with NUL, undefined-byte and UTF-8 hint counters.
`timescale 1ns / 1ps
`default_nettype none
// Takes one cp1252 byte per word and returns its UTF-8 form one byte per word, with
// backslash, tab, newline and carriage return escaped as two bytes. An input word yields
// one to three output bytes, sent one per word because the result port carries one byte
// per word; a NUL byte yields nothing. The next input word is taken once the last byte
// of the previous one moves into the result register. rsp_tlast marks the final byte of
// each input word; the three counts in rsp_tdata are the saturating counter values after
// that input word. Counters are COUNT_WIDTH bits wide, and the result carries their low
// 32 bits.
module cp1252_to_escaped_utf8 #(
   parameter int COUNT_WIDTH = c2eu8_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,  // [7:0] in_byte
   input  wire logic         req_tlast,  // value_end
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata,  // [7:0] out_byte, [39:8] nul_count,
                                         // [71:40] utf8_like_count, [103:72] undefined_count
   output logic              rsp_tlast   // last_of_run
);
   import c2eu8_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic                         req_accept;
   enc_type                      enc;

   logic [1:0]                   pending_ff, pending_in;
   logic [COUNT_WIDTH-1:0]       nul_ff, nul_in;
   logic [COUNT_WIDTH-1:0]       utf8_ff, utf8_in;
   logic [COUNT_WIDTH-1:0]       undef_ff, undef_in;

   logic                         hold_valid_ff, hold_valid_in;
   logic [MAX_BYTES-1:0][7:0]    hold_bytes_ff, hold_bytes_in;
   logic [1:0]                   hold_cnt_ff, hold_cnt_in;
   logic [1:0]                   hold_idx_ff, hold_idx_in;
   logic [3*FIELD_COUNT_WIDTH-1:0] hold_counts_ff, hold_counts_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [103:0]                 rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         load;
   logic                         hold_done;
   logic [1:0]                   need;
   logic                         cont_byte;

   assign load       = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign hold_done  = load && (hold_idx_ff == hold_cnt_ff - 2'd1);
   assign req_tready = !hold_valid_ff || hold_done;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign enc       = encode(req_tdata);
   assign cont_byte = (req_tdata[7:6] == 2'b10);

   always_comb begin
      if (req_tdata >= 8'hC2 && req_tdata <= 8'hDF) begin
         need = NEED_ONE;
      end else if (req_tdata >= 8'hE0 && req_tdata <= 8'hEF) begin
         need = NEED_TWO;
      end else if (req_tdata >= 8'hF0 && req_tdata <= 8'hF7) begin
         need = NEED_THREE;
      end else begin
         need = NEED_NONE;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      nul_in     = nul_ff;
      utf8_in    = utf8_ff;
      undef_in   = undef_ff;
      if (req_accept) begin
         if (need != NEED_NONE) begin
            pending_in = need;
         end else if (cont_byte && pending_ff != NEED_NONE) begin
            pending_in = pending_ff - 2'd1;
            if (pending_ff == NEED_ONE && utf8_ff != COUNT_MAX) begin
               utf8_in = utf8_ff + 1'b1;
            end
         end else begin
            pending_in = NEED_NONE;
         end
         if (req_tlast) begin
            pending_in = NEED_NONE;
         end
         if (req_tdata == 8'h00 && nul_ff != COUNT_MAX) begin
            nul_in = nul_ff + 1'b1;
         end
         if (enc.undef && undef_ff != COUNT_MAX) begin
            undef_in = undef_ff + 1'b1;
         end
      end
   end

   always_comb begin
      hold_valid_in  = hold_valid_ff;
      hold_bytes_in  = hold_bytes_ff;
      hold_cnt_in    = hold_cnt_ff;
      hold_idx_in    = hold_idx_ff;
      hold_counts_in = hold_counts_ff;
      if (load) begin
         hold_idx_in = hold_idx_ff + 2'd1;
      end
      if (hold_done) begin
         hold_valid_in = 1'b0;
      end
      if (req_accept && enc.cnt != 2'd0) begin
         hold_valid_in  = 1'b1;
         hold_bytes_in  = enc.bytes;
         hold_cnt_in    = enc.cnt;
         hold_idx_in    = 2'd0;
         hold_counts_in = {FIELD_COUNT_WIDTH'(undef_in), FIELD_COUNT_WIDTH'(utf8_in),
                           FIELD_COUNT_WIDTH'(nul_in)};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {hold_counts_ff, hold_bytes_ff[hold_idx_ff]};
         rsp_last_in  = (hold_idx_ff == hold_cnt_ff - 2'd1);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= NEED_NONE;
         nul_ff        <= '0;
         utf8_ff       <= '0;
         undef_ff      <= '0;
         hold_valid_ff <= 1'b0;
         hold_idx_ff   <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         nul_ff        <= nul_in;
         utf8_ff       <= utf8_in;
         undef_ff      <= undef_in;
         hold_valid_ff <= hold_valid_in;
         hold_idx_ff   <= hold_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_bytes_ff  <= hold_bytes_in;
      hold_cnt_ff    <= hold_cnt_in;
      hold_counts_ff <= hold_counts_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

`ifndef SYNTH
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (hold_cnt_ff != 2'd0 && hold_idx_ff < hold_cnt_ff))
      else $error("byte index beyond held count");

   a_pending_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (pending_ff == NEED_NONE))
      else $error("candidate sequence spans a value end");

   a_nul_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (nul_ff >= $past(nul_ff)))
      else $error("NUL counter went down");

   a_utf8_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (utf8_ff >= $past(utf8_ff)))
      else $error("UTF-8 hint counter went down");

   a_nul_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tdata == 8'h00) |=> (hold_valid_ff == $past(hold_valid_ff && !hold_done)))
      else $error("NUL byte produced output");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench: self-checking directed and random stimulus for the cp1252 to escaped UTF-8 converter.
`timescale 1ns / 1ps
module tb;
   import c2eu8_pkg::*;

   localparam int TALLY_W     = COUNT_WIDTH_DEFAULT;
   localparam int STUCK_LIMIT = 2000;
   localparam int RANDOM_CHARS = 330;

   // Unicode values of cp1252 0x80-0x9F, entry 0x00 in the lowest bits; zero marks undefined
   localparam logic [32*16-1:0] CP1252_HIGH = {
      16'h0178, 16'h017E, 16'h0000, 16'h0153, 16'h203A, 16'h0161, 16'h2122, 16'h02DC,
      16'h2014, 16'h2013, 16'h2022, 16'h201D, 16'h201C, 16'h2019, 16'h2018, 16'h0000,
      16'h0000, 16'h017D, 16'h0000, 16'h0152, 16'h2039, 16'h0160, 16'h2030, 16'h02C6,
      16'h2021, 16'h2020, 16'h2026, 16'h201E, 16'h0192, 16'h201A, 16'h0000, 16'h20AC};

   typedef struct {
      logic [7:0] code;
      logic       fin;
      bit         hold;
      bit         calm;
   } cp_char_type;

   typedef struct {
      logic [7:0]  ch;
      logic        last;
      logic [31:0] nul;
      logic [31:0] like;
      logic [31:0] undef;
   } utf8_byte_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;  // [7:0] in_byte
   logic         req_tlast  = 1'b0;   // value_end
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;           // [7:0] out_byte, [39:8] nul_count,
                                      // [71:40] utf8_like_count, [103:72] undefined_count
   logic         rsp_tlast;           // last_of_run

   cp_char_type   pending_chars[$];
   utf8_byte_type utf8_due[$];
   logic          drained = 1'b1;
   logic          steady  = 1'b0;
   bit            hold_next;
   int            errors;
   int            stuck;

   logic [1:0]         seq_need    = NEED_NONE;
   logic [TALLY_W-1:0] nul_tally   = '0;
   logic [TALLY_W-1:0] like_tally  = '0;
   logic [TALLY_W-1:0] undef_tally = '0;

   cp1252_to_escaped_utf8 #(
      .COUNT_WIDTH(TALLY_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic tally_bump(inout logic [TALLY_W-1:0] t);
      if (~&t) t = t + 1'b1;
   endtask

   task automatic transcode_char(input logic [7:0] c, input logic fin);
      logic [15:0]   cp;
      logic [7:0]    seq [0:2];
      int            n;
      utf8_byte_type r;
      n  = 0;
      cp = {8'h00, c};
      if (c >= 8'hC2 && c <= 8'hDF) begin
         seq_need = NEED_ONE;
      end else if (c >= 8'hE0 && c <= 8'hEF) begin
         seq_need = NEED_TWO;
      end else if (c >= 8'hF0 && c <= 8'hF7) begin
         seq_need = NEED_THREE;
      end else if (c[7:6] == 2'b10 && seq_need != NEED_NONE) begin
         seq_need = seq_need - 2'd1;
         if (seq_need == NEED_NONE) tally_bump(like_tally);
      end else begin
         seq_need = NEED_NONE;
      end
      if (c == 8'h00) begin
         tally_bump(nul_tally);
      end else begin
         if (c[7:5] == 3'b100) begin
            cp = CP1252_HIGH[c[4:0]*16 +: 16];
            if (cp == 16'h0000) begin
               tally_bump(undef_tally);
               cp = {8'h00, c};
            end
         end
         seq[0] = CH_BACKSLASH;
         n      = 2;
         if (cp == {8'h00, CH_BACKSLASH}) begin
            seq[1] = CH_BACKSLASH;
         end else if (cp == {8'h00, CH_TAB}) begin
            seq[1] = CH_LOWER_T;
         end else if (cp == {8'h00, CH_NEWLINE}) begin
            seq[1] = CH_LOWER_N;
         end else if (cp == {8'h00, CH_RETURN}) begin
            seq[1] = CH_LOWER_R;
         end else if (cp < 16'h0080) begin
            seq[0] = cp[7:0];
            n      = 1;
         end else if (cp < 16'h0800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end else begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n      = 3;
         end
      end
      if (fin) seq_need = NEED_NONE;
      for (int k = 0; k < n; k++) begin
         r.ch    = seq[k];
         r.last  = (k == n - 1);
         r.nul   = 32'(nul_tally);
         r.like  = 32'(like_tally);
         r.undef = 32'(undef_tally);
         utf8_due.push_back(r);
      end
   endtask

   task automatic add_char(input logic [7:0] c, input logic fin);
      cp_char_type s;
      s.code    = c;
      s.fin     = fin;
      s.hold    = hold_next;
      s.calm    = (pending_chars.size() >= 150 && pending_chars.size() < 230);
      hold_next = 1'b0;
      pending_chars.push_back(s);
   endtask

   // driver: present the next word, with random gaps outside the calm stretch
   always @(posedge clock) begin : send
      cp_char_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_chars.size() == 0 ||
             (pending_chars[0].hold && (req_tvalid || !drained)) ||
             (!pending_chars[0].calm && $urandom_range(0, 99) < 30)) begin
            req_tvalid <= 1'b0;
         end else begin
            nxt = pending_chars.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.code;
            req_tlast  <= nxt.fin;
            steady     <= nxt.calm;
         end
      end
   end

   always @(posedge clock) begin : sink
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 30);
      end
   end

   // monitor: predict on each accepted input word, then check each accepted output word
   always @(posedge clock) begin : watch
      utf8_byte_type got;
      utf8_byte_type want;
      logic          fired;
      if (!reset) begin
         fired = 1'b0;
         if (req_tvalid && req_tready) begin
            transcode_char(req_tdata, req_tlast);
            fired = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            fired     = 1'b1;
            got.ch    = rsp_tdata[7:0];
            got.last  = rsp_tlast;
            got.nul   = rsp_tdata[39:8];
            got.like  = rsp_tdata[71:40];
            got.undef = rsp_tdata[103:72];
            if (utf8_due.size() == 0) begin
               $error("out_byte: expected none, actual %02h", got.ch);
               errors++;
            end else begin
               want = utf8_due.pop_front();
               if (got.ch !== want.ch) begin
                  $error("out_byte: expected %02h, actual %02h", want.ch, got.ch);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
                  errors++;
               end
               if (got.nul !== want.nul) begin
                  $error("nul_count: expected %0d, actual %0d", want.nul, got.nul);
                  errors++;
               end
               if (got.like !== want.like) begin
                  $error("utf8_like_count: expected %0d, actual %0d", want.like, got.like);
                  errors++;
               end
               if (got.undef !== want.undef) begin
                  $error("undefined_count: expected %0d, actual %0d", want.undef, got.undef);
                  errors++;
               end
            end
         end
         drained <= (utf8_due.size() == 0);
         stuck = fired ? 0 : stuck + 1;
         if (stuck >= STUCK_LIMIT) begin
            $display("cp1252_to_escaped_utf8: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int          kind;
      int          len;
      int          cut;
      bit          held_mid;
      logic [7:0]  lead;
      held_mid  = 1'b0;
      hold_next = 1'b0;

      add_char(8'h00, 1'b0);
      add_char(8'h5C, 1'b0);
      add_char(8'h09, 1'b0);
      add_char(8'h0A, 1'b0);
      add_char(8'h0D, 1'b0);
      add_char(8'h7F, 1'b0);
      add_char(8'h81, 1'b0);
      add_char(8'h9D, 1'b0);
      add_char(8'h80, 1'b0);
      add_char(8'h9F, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(8'hC1, 1'b1);
      add_char(8'hC3, 1'b0);
      add_char(8'hA9, 1'b1);
      add_char(8'hE2, 1'b0);
      add_char(8'h82, 1'b0);
      add_char(8'hAC, 1'b1);
      add_char(8'hF0, 1'b0);
      add_char(8'h9F, 1'b0);
      add_char(8'h98, 1'b0);
      add_char(8'h80, 1'b1);
      add_char(8'hC3, 1'b1);
      add_char(8'hA9, 1'b0);
      add_char(8'hE2, 1'b0);
      add_char(8'hC3, 1'b0);
      add_char(8'hA9, 1'b0);
      add_char(8'h41, 1'b1);

      hold_next = 1'b1;
      cut       = pending_chars.size();
      while (pending_chars.size() < cut + RANDOM_CHARS) begin
         if (!held_mid && pending_chars.size() >= 250) begin
            hold_next = 1'b1;
            held_mid  = 1'b1;
         end
         kind = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         case (len)
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
         endcase
         if (kind < 55) begin
            add_char(lead, 1'b0);
            for (int k = 1; k < len; k++) begin
               add_char(8'($urandom_range(8'h80, 8'hBF)),
                        (k == len - 1) && ($urandom_range(0, 2) == 0));
            end
         end else if (kind < 70) begin
            add_char(lead, 1'b0);
            for (int k = 0; k < $urandom_range(0, len - 2); k++) begin
               add_char(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
            if ($urandom_range(0, 1) == 0) begin
               add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               add_char(8'($urandom_range(0, 8'h7F)), 1'b1);
               add_char(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
            end
         end else if (kind < 80) begin
            case ($urandom_range(0, 9))
               0, 1: lead = 8'h00;
               2: lead = CH_BACKSLASH;
               3: lead = CH_TAB;
               4: lead = CH_NEWLINE;
               5: lead = CH_RETURN;
               6: lead = 8'h8D;
               7: lead = 8'h8F;
               8: lead = 8'h90;
               default: lead = 8'($urandom_range(8'hF8, 8'hFF));
            endcase
            add_char(lead, 1'($urandom_range(0, 3) == 0));
         end else begin
            add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_tvalid || !drained || utf8_due.size() != 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && utf8_due.size() == 0) begin
         $display("cp1252_to_escaped_utf8: match");
      end else begin
         $display("cp1252_to_escaped_utf8: mismatch");
      end
      $finish;
   end

endmodule
